// ----- design/frx_pkg.sv -----
// ----------------------------------------------------------------------------
// frx_pkg
// Shared constants and types of the frame row receiver: message command
// codes, default geometry and queue depth, reset brightness and the front-to-back op code.
// ----------------------------------------------------------------------------
`default_nettype none

package frx_pkg;

  localparam logic [7:0] CMD_BEGIN        = 8'hF0;
  localparam logic [7:0] CMD_ROW          = 8'hF1;
  localparam logic [7:0] CMD_END          = 8'hF2;
  localparam logic [7:0] RESET_BRIGHTNESS = 8'd32;

  localparam int PIXELS_PER_ROW_DEF = 8;
  localparam int ROW_COUNT_DEF      = 8;
  localparam int QUEUE_DEPTH        = 4;

  typedef enum logic {
    OP_STAGE,
    OP_EMIT
  } op_t;

endpackage

`default_nettype wire

// ----- design/frame_row_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// frame_row_receiver_unit
// Receives message bytes, builds a frame of RGB pixels row by row and
// streams the frame out with its brightness on frame end.
//
// Usage:
//   Input channel (msg_valid/msg_ready) takes one message byte per
//   transaction, first_of_message marking the command byte. A byte is
//   accepted whenever the op queue has room.
//   Output channel (pixel_valid/pixel_ready) carries one pixel per
//   transaction; a frame end command yields ROW_COUNT * PIXELS_PER_ROW
//   transactions in row-major order, last_pixel set on the final one.
//   Emission: a frame end reaches the back end through the queue; once
//   it is popped, each pixel passes through the RAM read, load and
//   present states in turn. A completed row is copied into the frame
//   store RAM one pixel at a time, PIXELS_PER_ROW writes in all.
//   When the receiver stalls, the back end holds its pixel and the
//   front end keeps taking bytes until the queue fills.
//   Reset clears the row valid bits at once, so the whole frame reads as
//   zero with no clearing pass; brightness returns to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_row_receiver_unit #(
  parameter int PIXELS_PER_ROW = frx_pkg::PIXELS_PER_ROW_DEF,
  parameter int ROW_COUNT      = frx_pkg::ROW_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       msg_valid,
  output logic            msg_ready,
  input  wire logic [7:0] msg_byte,
  input  wire logic       first_of_message,
  output logic            pixel_valid,
  input  wire logic       pixel_ready,
  output logic      [5:0] pixel_index,
  output logic      [7:0] red,
  output logic      [7:0] green,
  output logic      [7:0] blue,
  output logic      [7:0] brightness,
  output logic            last_pixel
);

  import frx_pkg::*;

  localparam int PIX_W   = (PIXELS_PER_ROW > 1) ? $clog2(PIXELS_PER_ROW) : 1;
  localparam int ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int STORE   = PIXELS_PER_ROW * ROW_COUNT;
  localparam int IDX_W   = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int ENTRY_W = 12 + PIX_W + ROW_W;

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_pop_data;
  logic               q_full;
  logic               q_empty;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [23:0]        ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [23:0]        ram_rdata;

  frx_front #(
    .PIXELS_PER_ROW (PIXELS_PER_ROW),
    .ROW_COUNT      (ROW_COUNT)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .msg_valid        (msg_valid),
    .msg_ready        (msg_ready),
    .msg_byte         (msg_byte),
    .first_of_message (first_of_message),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_push_data)
  );

  frx_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  frx_back #(
    .PIXELS_PER_ROW (PIXELS_PER_ROW),
    .ROW_COUNT      (ROW_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .brightness  (brightness),
    .last_pixel  (last_pixel)
  );

  frx_ram #(
    .WIDTH (24),
    .DEPTH (STORE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- design/frx_ram.sv -----
// ----------------------------------------------------------------------------
// frx_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/frx_queue.sv -----
// ----------------------------------------------------------------------------
// frx_queue
// Short first-in first-out queue of ops between the message front end and
// the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module frx_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = frx_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/frx_front.sv -----
// ----------------------------------------------------------------------------
// frx_front
// Message front end: tracks the open command, counts bytes, takes the
// brightness and row number, and queues stage and emit ops for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module frx_front #(
  parameter int PIXELS_PER_ROW = frx_pkg::PIXELS_PER_ROW_DEF,
  parameter int ROW_COUNT      = frx_pkg::ROW_COUNT_DEF,
  localparam int PIX_W   = (PIXELS_PER_ROW > 1) ? $clog2(PIXELS_PER_ROW) : 1,
  localparam int ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1,
  localparam int ENTRY_W = 12 + PIX_W + ROW_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               msg_valid,
  output logic                    msg_ready,
  input  wire logic [7:0]         msg_byte,
  input  wire logic               first_of_message,
  input  wire logic               q_full,
  output logic                    q_push,
  output logic      [ENTRY_W-1:0] q_data
);

  import frx_pkg::*;

  localparam int ROW_BYTES = 2 + 3 * PIXELS_PER_ROW;
  localparam int CNT_W     = $clog2(ROW_BYTES + 1);

  typedef struct packed {
    op_t              op;
    logic             commit;
    logic [7:0]       value;
    logic [1:0]       comp;
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
  } entry_t;

  typedef enum logic [1:0] {
    MC_NONE,
    MC_BEGIN,
    MC_ROW
  } mc_t;

  mc_t              message_command;
  logic [CNT_W-1:0] byte_count;
  logic [ROW_W-1:0] row_number;
  logic             row_ok;
  logic [7:0]       brightness_level;
  logic [PIX_W-1:0] pix;
  logic [1:0]       comp;

  logic   accept;
  logic   stage_byte;
  entry_t entry;

  assign msg_ready = !q_full;
  assign accept    = msg_valid && msg_ready;
  assign stage_byte = !first_of_message && (message_command == MC_ROW) &&
                      (byte_count >= CNT_W'(2)) && (byte_count < CNT_W'(ROW_BYTES));

  always_comb begin
    q_push       = 1'b0;
    entry.op     = OP_STAGE;
    entry.commit = 1'b0;
    entry.value  = msg_byte;
    entry.comp   = comp;
    entry.pix    = pix;
    entry.row    = row_number;
    if (accept) begin
      if (first_of_message && msg_byte == CMD_END) begin
        q_push      = 1'b1;
        entry.op    = OP_EMIT;
        entry.value = brightness_level;
      end else if (stage_byte) begin
        q_push       = 1'b1;
        entry.commit = (byte_count == CNT_W'(ROW_BYTES - 1)) && row_ok;
      end
    end
  end

  assign q_data = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_command  <= MC_NONE;
      byte_count       <= '0;
      row_number       <= '0;
      row_ok           <= 1'b0;
      brightness_level <= RESET_BRIGHTNESS;
      pix              <= '0;
      comp             <= '0;
    end else if (accept) begin
      if (first_of_message) begin
        byte_count <= CNT_W'(1);
        unique case (msg_byte)
          CMD_BEGIN: message_command <= MC_BEGIN;
          CMD_ROW:   message_command <= MC_ROW;
          default:   message_command <= MC_NONE;
        endcase
      end else begin
        if (message_command == MC_BEGIN && byte_count == CNT_W'(1)) begin
          brightness_level <= msg_byte;
        end
        if (message_command == MC_ROW && byte_count == CNT_W'(1)) begin
          row_number <= ROW_W'(msg_byte);
          row_ok     <= (msg_byte < 8'(ROW_COUNT));
          pix        <= '0;
          comp       <= '0;
        end
        if (stage_byte) begin
          if (comp == 2'd2) begin
            comp <= '0;
            pix  <= pix + 1'b1;
          end else begin
            comp <= comp + 1'b1;
          end
        end
        if (byte_count != CNT_W'(ROW_BYTES)) begin
          byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/frx_back.sv -----
// ----------------------------------------------------------------------------
// frx_back
// Pixel back end: applies staged color bytes, copies a finished row into
// the frame store and streams the whole store out on frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module frx_back #(
  parameter int PIXELS_PER_ROW = frx_pkg::PIXELS_PER_ROW_DEF,
  parameter int ROW_COUNT      = frx_pkg::ROW_COUNT_DEF,
  localparam int PIX_W   = (PIXELS_PER_ROW > 1) ? $clog2(PIXELS_PER_ROW) : 1,
  localparam int ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1,
  localparam int STORE   = PIXELS_PER_ROW * ROW_COUNT,
  localparam int IDX_W   = (STORE > 1) ? $clog2(STORE) : 1,
  localparam int ENTRY_W = 12 + PIX_W + ROW_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    q_pop,
  output logic                    ram_we,
  output logic      [IDX_W-1:0]   ram_waddr,
  output logic      [23:0]        ram_wdata,
  output logic                    ram_re,
  output logic      [IDX_W-1:0]   ram_raddr,
  input  wire logic [23:0]        ram_rdata,
  output logic                    pixel_valid,
  input  wire logic               pixel_ready,
  output logic      [5:0]         pixel_index,
  output logic      [7:0]         red,
  output logic      [7:0]         green,
  output logic      [7:0]         blue,
  output logic      [7:0]         brightness,
  output logic                    last_pixel
);

  import frx_pkg::*;

  typedef struct packed {
    op_t              op;
    logic             commit;
    logic [7:0]       value;
    logic [1:0]       comp;
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_READ,
    S_LOAD,
    S_SHOW
  } state_t;

  state_t           state;
  entry_t           entry;
  logic [23:0]      staging [PIXELS_PER_ROW];
  logic [ROW_COUNT-1:0] row_valid;
  logic [ROW_W-1:0] copy_row;
  logic [PIX_W-1:0] copy_cnt;
  logic [IDX_W-1:0] idx;
  logic [PIX_W-1:0] col;
  logic [ROW_W-1:0] erow;
  logic             read_ok;
  logic [7:0]       emit_bright;

  assign entry       = q_data;
  assign pixel_valid = (state == S_SHOW);

  always_comb begin
    q_pop     = (state == S_IDLE) && !q_empty;
    ram_we    = (state == S_COPY);
    ram_waddr = IDX_W'(copy_row * PIXELS_PER_ROW + copy_cnt);
    ram_wdata = staging[copy_cnt];
    ram_re    = (state == S_READ);
    ram_raddr = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      copy_row  <= '0;
      copy_cnt  <= '0;
      idx       <= '0;
      col       <= '0;
      erow      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (entry.op == OP_EMIT) begin
              emit_bright <= entry.value;
              idx         <= '0;
              col         <= '0;
              erow        <= '0;
              state       <= S_READ;
            end else begin
              unique case (entry.comp)
                2'd0:    staging[entry.pix][23:16] <= entry.value;
                2'd1:    staging[entry.pix][15:8]  <= entry.value;
                2'd2:    staging[entry.pix][7:0]   <= entry.value;
                default: ;
              endcase
              if (entry.commit) begin
                copy_row <= entry.row;
                copy_cnt <= '0;
                state    <= S_COPY;
              end
            end
          end
        end
        S_COPY: begin
          if (copy_cnt == PIX_W'(PIXELS_PER_ROW - 1)) begin
            row_valid[copy_row] <= 1'b1;
            state               <= S_IDLE;
          end else begin
            copy_cnt <= copy_cnt + 1'b1;
          end
        end
        S_READ: begin
          read_ok <= row_valid[erow];
          state   <= S_LOAD;
        end
        S_LOAD: begin
          pixel_index <= 6'(idx);
          red         <= read_ok ? ram_rdata[23:16] : 8'd0;
          green       <= read_ok ? ram_rdata[15:8]  : 8'd0;
          blue        <= read_ok ? ram_rdata[7:0]   : 8'd0;
          brightness  <= emit_bright;
          last_pixel  <= (idx == IDX_W'(STORE - 1));
          state       <= S_SHOW;
        end
        S_SHOW: begin
          if (pixel_ready) begin
            if (idx == IDX_W'(STORE - 1)) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              if (col == PIX_W'(PIXELS_PER_ROW - 1)) begin
                col  <= '0;
                erow <= erow + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |=> pixel_valid)
    else $error("loaded pixel not presented");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && last_pixel |=> state == S_IDLE)
    else $error("emission continued past last pixel");

  a_commit_marks: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY && copy_cnt == PIX_W'(PIXELS_PER_ROW - 1)
      |=> row_valid[$past(copy_row)])
    else $error("committed row not marked valid");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && !last_pixel
      |=> state == S_READ && idx == $past(idx) + 1'b1)
    else $error("emission index did not advance");
`endif

endmodule

`default_nettype wire
